/* hw/rtl/ehr_pkg.sv */
// shared types and codes for the emitter histogram renderer
package ehr_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2,
    OP_NONE       = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_SCALE_X       = 3'd2;
  localparam logic [2:0] REG_SCALE_Y       = 3'd3;
  localparam logic [2:0] REG_WIDTH_IN_USE  = 3'd4;
  localparam logic [2:0] REG_HEIGHT_IN_USE = 3'd5;

  // register reset values
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [8:0]  SIZE_RESET  = 9'd256;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_LOOK,
    ST_UPDATE
  } state_t;

  // mapped pixel coordinate of one axis
  typedef struct packed {
    logic [31:0] idx;
    logic        ok;
  } coord_t;

endpackage

/* hw/rtl/ehr_pixel_mem.sv */
// pixel accumulator memory, one write and one registered read port
module ehr_pixel_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/ehr_coord_map.sv */
// maps one position axis to a pixel index: offset, scale, floor
module ehr_coord_map (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   pos,
  input  logic [31:0]   origin,
  input  logic [31:0]   scale,
  output ehr_pkg::coord_t coord
);

  logic [32:0] d_off;
  logic [63:0] prod_nxt;
  logic        ok_nxt;
  logic [63:0] prod_r;
  logic        ok_r;

  // signed offset, exact in 33 bits
  assign d_off = {pos[31], pos} - {origin[31], origin};

  // 32x32 product of the offset magnitude and the 16.16 scale gives 32.32
  assign prod_nxt = 64'(d_off[31:0]) * 64'(scale);

  // negative offset drops the point unless the scale is zero (index 0)
  assign ok_nxt = !d_off[32] || (scale == 32'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      ok_r   <= ok_nxt;
    end
  end

  // floor is the integer half of the product
  assign coord.idx = prod_r[63:32];
  assign coord.ok  = ok_r;

endmodule

/* hw/rtl/emitter_histogram_render.sv */
// Emitter histogram renderer: adds emitter localizations into a pixel histogram held in one
// memory of MAX_WIDTH*MAX_HEIGHT 32-bit words and reads pixels back, optionally clearing them.
// After reset a clearing pass writes zero to every word, one a cycle; no item is taken during it,
// configuration writes are. Each item then passes through acceptance, the coordinate multiply,
// the memory read and the update with write-back. The single read-modify-write of the pixel
// memory keeps one item in flight at a time: the next item is taken in the cycle after the
// result is loaded into the output register, and a stalled result holds the update until the
// output is free. Every item gives exactly one result. Configuration writes are always ready.
module emitter_histogram_render #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_intensity,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [7:0]  in_read_col,
  input  logic [7:0]  in_read_row,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_value,
  output logic        out_in_range,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [31:0] origin_x_r, origin_y_r, scale_x_r, scale_y_r;
  logic [8:0]  width_in_use_r, height_in_use_r;

  // captured item
  ehr_pkg::opcode_t op_r;
  logic [15:0] inten_r;
  logic [31:0] pos_x_r, pos_y_r;
  logic [7:0]  rcol_r, rrow_r;

  // sequencer
  ehr_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_last;

  // lookup stage
  logic [AW-1:0] addr_r, addr_nxt;
  logic          hit_r, hit_nxt;

  // output register
  logic        out_valid_r;
  logic [31:0] out_pixel_value_r;
  logic        out_in_range_r;

  // datapath
  ehr_pkg::coord_t cx, cy;
  logic        in_acc, out_free, upd_go, map_en;
  logic [31:0] w_eff, h_eff, col_idx, row_idx;
  logic        is_add, is_read;
  logic [31:0] rd_data;
  logic [32:0] sum;
  logic [31:0] upd_value;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign upd_go   = (state_r == ehr_pkg::ST_UPDATE) && out_free;
  assign map_en   = (state_r == ehr_pkg::ST_MAP);
  assign clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  assign in_ready  = (state_r == ehr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      scale_x_r       <= ehr_pkg::SCALE_RESET;
      scale_y_r       <= ehr_pkg::SCALE_RESET;
      width_in_use_r  <= ehr_pkg::SIZE_RESET;
      height_in_use_r <= ehr_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ehr_pkg::REG_ORIGIN_X:      origin_x_r      <= cfg_data;
        ehr_pkg::REG_ORIGIN_Y:      origin_y_r      <= cfg_data;
        ehr_pkg::REG_SCALE_X:       scale_x_r       <= cfg_data;
        ehr_pkg::REG_SCALE_Y:       scale_y_r       <= cfg_data;
        ehr_pkg::REG_WIDTH_IN_USE:  width_in_use_r  <= cfg_data[8:0];
        ehr_pkg::REG_HEIGHT_IN_USE: height_in_use_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= ehr_pkg::opcode_t'(in_opcode);
      inten_r <= in_intensity;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      rcol_r  <= in_read_col;
      rrow_r  <= in_read_row;
    end
  end

  // coordinate mapping, one unit per axis
  ehr_coord_map u_map_x (
    .clk    (clk),
    .en     (map_en),
    .pos    (pos_x_r),
    .origin (origin_x_r),
    .scale  (scale_x_r),
    .coord  (cx)
  );

  ehr_coord_map u_map_y (
    .clk    (clk),
    .en     (map_en),
    .pos    (pos_y_r),
    .origin (origin_y_r),
    .scale  (scale_y_r),
    .coord  (cy)
  );

  // image size in use, capped at the memory size
  assign w_eff = (32'(width_in_use_r) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH)
                                                        : 32'(width_in_use_r);
  assign h_eff = (32'(height_in_use_r) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                          : 32'(height_in_use_r);

  // pixel lookup: range check and address
  always_comb begin
    is_add  = (op_r == ehr_pkg::OP_ADD);
    is_read = (op_r == ehr_pkg::OP_READ) || (op_r == ehr_pkg::OP_READ_CLEAR);
    col_idx = is_add ? cx.idx : 32'(rcol_r);
    row_idx = is_add ? cy.idx : 32'(rrow_r);
    hit_nxt = (col_idx < w_eff) && (row_idx < h_eff)
              && ((is_add && cx.ok && cy.ok) || is_read);
    addr_nxt = AW'(row_idx[RW-1:0]) * AW'(MAX_WIDTH) + AW'(col_idx[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (state_r == ehr_pkg::ST_LOOK) begin
      addr_r <= addr_nxt;
      hit_r  <= hit_nxt;
    end
  end

  // saturating accumulate
  assign sum       = {1'b0, rd_data} + 33'(inten_r);
  assign upd_value = (op_r == ehr_pkg::OP_ADD) ? (sum[32] ? '1 : sum[31:0]) : '0;

  // memory port control
  always_comb begin
    mem_re    = (state_r == ehr_pkg::ST_LOOK);
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = upd_value;
    if (state_r == ehr_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (upd_go && hit_r
                 && (op_r == ehr_pkg::OP_ADD || op_r == ehr_pkg::OP_READ_CLEAR)) begin
      mem_we = 1'b1;
    end
  end

  ehr_pixel_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_nxt),
    .rdata (rd_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ehr_pkg::ST_CLEAR:  if (clr_last) state_nxt = ehr_pkg::ST_IDLE;
      ehr_pkg::ST_IDLE:   if (in_acc) state_nxt = ehr_pkg::ST_MAP;
      ehr_pkg::ST_MAP:    state_nxt = ehr_pkg::ST_LOOK;
      ehr_pkg::ST_LOOK:   state_nxt = ehr_pkg::ST_UPDATE;
      ehr_pkg::ST_UPDATE: if (out_free) state_nxt = ehr_pkg::ST_IDLE;
      default:            state_nxt = ehr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ehr_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ehr_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_pixel_value_r <= (hit_r && op_r != ehr_pkg::OP_ADD) ? rd_data : '0;
      out_in_range_r    <= hit_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_in_range    = out_in_range_r;

`ifndef ASSERT_OFF
  // an accepted item always moves on to the multiply
  a_accept_maps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ehr_pkg::ST_MAP)
    else $error("accepted item did not enter the map stage");

  // a new result only comes from the update step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ehr_pkg::ST_UPDATE)
    else $error("result appeared outside the update step");

  // item writes only touch a pixel that was in range
  a_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ehr_pkg::ST_CLEAR) |-> (hit_r && upd_go))
    else $error("pixel write without an in-range update");

  // no item is taken while the memory is being cleared
  a_no_item_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ehr_pkg::ST_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing pass");
`endif

endmodule

/* tb/sv/histogram_check_pkg.sv */
// scoreboard for the emitter histogram renderer: pixel store prediction and result checks
package histogram_check_pkg;
  import ehr_pkg::*;

  localparam int IMG_W = 256;
  localparam int IMG_H = 256;

  // one predicted result item
  typedef struct packed {
    logic [31:0] value;
    logic        hit;
  } pixel_result_t;

  class histogram_scoreboard;
    logic [31:0]   pixels [IMG_W*IMG_H];
    logic [31:0]   org_x, org_y, scl_x, scl_y;
    logic [8:0]    wid, hgt;
    pixel_result_t due_q [$];
    int            errors;
    int            compared;
    int            landed;
    int            reads;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      org_x    = '0;
      org_y    = '0;
      scl_x    = SCALE_RESET;
      scl_y    = SCALE_RESET;
      wid      = SIZE_RESET;
      hgt      = SIZE_RESET;
      errors   = 0;
      compared = 0;
      landed   = 0;
      reads    = 0;
    endfunction

    // register write as seen on the cfg channel
    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_ORIGIN_X:      org_x = data;
        REG_ORIGIN_Y:      org_y = data;
        REG_SCALE_X:       scl_x = data;
        REG_SCALE_Y:       scl_y = data;
        REG_WIDTH_IN_USE:  wid   = data[8:0];
        REG_HEIGHT_IN_USE: hgt   = data[8:0];
        default: ;
      endcase
    endfunction

    // floor of (pos - org) * scale; zero means dropped below the origin
    function bit map_axis(logic [31:0] pos, logic [31:0] org, logic [31:0] scale,
                          output logic [31:0] idx);
      longint      d;
      logic [63:0] du, prod;
      d   = longint'($signed(pos)) - longint'($signed(org));
      idx = '0;
      if (d < 0) return (scale == 32'd0);
      du   = d;
      prod = du * {32'd0, scale};
      idx  = prod[63:32];
      return 1'b1;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    // predict the result of one accepted item and update the pixel store
    function void note_item(opcode_t op, logic [15:0] inten, logic [31:0] px, logic [31:0] py,
                            logic [7:0] rc, logic [7:0] rr);
      logic [31:0]   c, r;
      logic [8:0]    w, h;
      logic [32:0]   sum;
      int unsigned   a;
      pixel_result_t res;
      w   = (wid > 9'd256) ? 9'd256 : wid;
      h   = (hgt > 9'd256) ? 9'd256 : hgt;
      res = '0;
      case (op)
        OP_ADD: begin
          if (map_axis(px, org_x, scl_x, c) && map_axis(py, org_y, scl_y, r) &&
              c < w && r < h) begin
            a         = r * IMG_W + c;
            sum       = {1'b0, pixels[a]} + inten;
            pixels[a] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            res.hit   = 1'b1;
            landed++;
          end
        end
        OP_READ, OP_READ_CLEAR: begin
          reads++;
          if (rc < w && rr < h) begin
            a         = rr * IMG_W + rc;
            res.value = pixels[a];
            res.hit   = 1'b1;
            if (op == OP_READ_CLEAR) pixels[a] = '0;
          end
        end
        default: ;
      endcase
      due_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch on result %0d: %s", compared, what);
    endtask

    // compare one accepted result with the oldest prediction
    task check_result(logic [31:0] value, logic hit);
      pixel_result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result value %08h in_range %0b", value, hit));
        return;
      end
      want = due_q.pop_front();
      compared++;
      if (value !== want.value)
        report($sformatf("pixel_value %08h, predicted %08h", value, want.value));
      if (hit !== want.hit)
        report($sformatf("in_range %0b, predicted %0b", hit, want.hit));
    endtask
  endclass

endpackage

/* tb/sv/tb.sv */
// top-level testbench for the emitter histogram renderer
module tb;
  import ehr_pkg::*;
  import histogram_check_pkg::*;

  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 130;
  localparam int PILE_ADDS     = 24;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [15:0] in_intensity;
  logic [31:0] in_pos_x;
  logic [31:0] in_pos_y;
  logic [7:0]  in_read_col;
  logic [7:0]  in_read_row;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] out_pixel_value;
  logic        out_in_range;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  histogram_scoreboard sb;
  logic        steady = 1'b0;
  int          cycle_count = 0;
  int          items_sent;
  int          settings_done;
  logic [31:0] cur_ox, cur_oy, cur_sx, cur_sy;
  int          cur_w, cur_h;

  emitter_histogram_render u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_intensity    (in_intensity),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_read_col     (in_read_col),
    .in_read_row     (in_read_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value),
    .out_in_range    (out_in_range),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result items are checked as they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_pixel_value, out_in_range);
  end

  // result-side stalls
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 7);
  end

  // offer one item, with an occasional gap in front of it
  task automatic put_item(opcode_t op, logic [15:0] inten, logic [31:0] px, logic [31:0] py,
                          logic [7:0] rc, logic [7:0] rr);
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_intensity <= inten;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_read_col  <= rc;
    in_read_row  <= rr;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, inten, px, py, rc, rr);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering items and wait for every result to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // write all six registers back to back
  task automatic apply_setting(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
                               logic [31:0] sy, logic [31:0] wd, logic [31:0] hd);
    logic [31:0] vals [6];
    logic [2:0]  regs [6];
    regs = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_SCALE_X, REG_SCALE_Y,
             REG_WIDTH_IN_USE, REG_HEIGHT_IN_USE};
    vals = '{ox, oy, sx, sy, wd, hd};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_ox = ox;
    cur_oy = oy;
    cur_sx = sx;
    cur_sy = sy;
    cur_w  = (wd[8:0] > 9'd256) ? 256 : int'(wd[8:0]);
    cur_h  = (hd[8:0] > 9'd256) ? 256 : int'(hd[8:0]);
    settings_done++;
  endtask

  // position along one axis: mostly aimed at the first pixels, some below origin, some wild
  function automatic logic [31:0] pick_pos(logic [31:0] org, logic [31:0] scale, int size);
    logic [63:0] lim, d;
    int          span;
    int          roll;
    roll = $urandom_range(0, 99);
    span = ($urandom_range(0, 9) < 7 && size > 16) ? 16 : size;
    if (roll >= 90) return $urandom;
    if (roll >= 80) return org - $urandom_range(1, 32'h0003_0000);
    if (scale == 32'd0) lim = 64'hFFFF_FFFF;
    else lim = (64'(span) << 32) / scale;
    if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    d = {$urandom, $urandom} % (lim + 1);
    return org + d[31:0];
  endfunction

  // read address along one axis, mostly where adds have been landing
  function automatic logic [7:0] pick_index(int size);
    if (size == 0 || $urandom_range(0, 9) < 3) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, (size > 16 ? 16 : size) - 1));
  endfunction

  task automatic random_item();
    int          roll;
    opcode_t     op;
    logic [15:0] inten;
    roll = $urandom_range(0, 99);
    if (roll < 55) op = OP_ADD;
    else if (roll < 75) op = OP_READ;
    else if (roll < 95) op = OP_READ_CLEAR;
    else op = OP_NONE;
    case ($urandom_range(0, 9))
      0:       inten = 16'h0000;
      1:       inten = 16'hFFFF;
      default: inten = 16'($urandom);
    endcase
    put_item(op, inten, pick_pos(cur_ox, cur_sx, cur_w), pick_pos(cur_oy, cur_sy, cur_h),
             pick_index(cur_w), pick_index(cur_h));
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_ADD;
    in_intensity  = '0;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_read_col   = '0;
    in_read_row   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ORIGIN_X;
    cfg_data      = '0;
    items_sent    = 0;
    settings_done = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // identity mapping: image edges, outside points, read and clear
    apply_setting(32'd0, 32'd0, SCALE_RESET, SCALE_RESET, 32'd256, 32'd256);
    put_item(OP_ADD, 16'hFFFF, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd1, 32'h00FF_FFFF, 32'h00FF_FFFF, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd3, 32'h0100_0000, 32'h0000_0000, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd4, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd5, 32'h7FFF_FFFF, 32'h0000_0000, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd6, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd0, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'd0);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd0, 8'd0);
    put_item(OP_READ_CLEAR, 16'd0, 32'd0, 32'd0, 8'd0, 8'd0);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd0, 8'd0);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd255, 8'd255);
    put_item(OP_NONE, 16'($urandom), $urandom, $urandom, 8'd255, 8'd255);

    // extreme origins and scales, zero scale below origin, oversized width, one row
    drain();
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd511, 32'd1);
    put_item(OP_ADD, 16'd7, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd8, 32'h7FFF_FFFF, 32'h8000_0001, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd9, 32'h7FFF_FFFF, 32'h8000_0002, 8'd0, 8'd0);
    put_item(OP_ADD, 16'd10, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd0);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd255, 8'd0);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd0, 8'd1);

    // zero width: nothing is in the image
    drain();
    apply_setting(32'd0, 32'd0, SCALE_RESET, SCALE_RESET, 32'd0, 32'd256);
    put_item(OP_ADD, 16'd11, 32'd0, 32'd0, 8'd0, 8'd0);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd0, 8'd0);

    // small image: a bad read address must not clear anything
    drain();
    apply_setting(32'd0, 32'd0, SCALE_RESET, SCALE_RESET, 32'd10, 32'd10);
    put_item(OP_ADD, 16'd5, 32'h0003_8000, 32'h0003_0001, 8'd0, 8'd0);
    put_item(OP_READ_CLEAR, 16'd0, 32'd0, 32'd0, 8'd200, 8'd3);
    put_item(OP_READ_CLEAR, 16'd0, 32'd0, 32'd0, 8'd3, 8'd3);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd3, 8'd3);

    // pile full-scale adds onto one pixel
    drain();
    apply_setting(32'd0, 32'd0, SCALE_RESET, SCALE_RESET, 32'd256, 32'd256);
    repeat (PILE_ADDS)
      put_item(OP_ADD, 16'hFFFF, {16'd7, 16'($urandom)}, {16'd9, 16'($urandom)},
               8'($urandom), 8'($urandom));
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd7, 8'd9);
    put_item(OP_READ_CLEAR, 16'd0, 32'd0, 32'd0, 8'd7, 8'd9);
    put_item(OP_READ, 16'd0, 32'd0, 32'd0, 8'd7, 8'd9);

    // random traffic under a series of register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_setting(32'd0, 32'd0, SCALE_RESET, SCALE_RESET, 32'd256, 32'd256);
        1: apply_setting($urandom_range(0, 32'h00FF_FFFF), 32'hFF00_0000 + $urandom_range(0, 255),
                         $urandom_range(32'h4000, 32'h4_0000), $urandom_range(32'h4000, 32'h4_0000),
                         $urandom_range(1, 256), $urandom_range(1, 256));
        2: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        3: apply_setting($urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd256, 32'd256);
        default: apply_setting(32'h8000_0000, 32'd0, 32'd0, 32'd1, 32'd511, 32'd1);
      endcase
      // the second phase runs with no stalls on either side
      steady = (ph == 1);
      repeat (PHASE_ITEMS) random_item();
    end
    steady = 1'b0;

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d items under %0d register settings, %0d emitters landed in the image",
             items_sent, settings_done, sb.landed);
    $display("%0d pixel reads, %0d results compared, one pixel loaded with full-scale adds",
             sb.reads, sb.compared);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
